// ----- rtl/core/cwca_pkg.sv -----
// ----------------------------------------------------------------------------
// cwca_pkg
// Shared types and constants for the carrier wipe-off chip averager.
// ----------------------------------------------------------------------------
package cwca_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_STEP    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_STEP = 1'b1;

    // Field widths that do not vary.
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned BIN_W   = 12;

    // Four-phase carrier bit tables, entry n at bit n.
    localparam logic [3:0] SIN_BITS = 4'b0011;
    localparam logic [3:0] COS_BITS = 4'b1001;

    // One chip result, with its valid flag, from datapath to output buffer.
    typedef struct packed {
        logic              valid;
        logic              i_bit;
        logic              q_bit;
        logic [BIN_W-1:0]  bin_index;
    } t_chip_word;

endpackage

// ----- rtl/core/cwca_datapath.sv -----
// ----------------------------------------------------------------------------
// cwca_datapath
// Carrier wipe-off, saturating I/Q integration, code phase chip detection.
// ----------------------------------------------------------------------------
module cwca_datapath #(
    parameter int unsigned BIN_COUNT = 4096,
    parameter int unsigned SUM_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cwca_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [cwca_pkg::PHASE_W-1:0]         i_cfg_data,
    input  logic                                 i_accept,
    input  logic                                 i_sample_bit,
    input  logic                                 i_restart,
    output cwca_pkg::t_chip_word                 o_word
);

    localparam int unsigned CHIP_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic [CHIP_W-1:0] BIN_LAST = CHIP_W'(BIN_COUNT - 1);

    logic [cwca_pkg::PHASE_W-1:0] r_code_step;
    logic [cwca_pkg::PHASE_W-1:0] r_carrier_step;
    logic [cwca_pkg::PHASE_W-1:0] r_carrier_phase;
    logic [cwca_pkg::PHASE_W-1:0] r_code_acc;
    logic signed [SUM_WIDTH-1:0]  r_i_sum;
    logic signed [SUM_WIDTH-1:0]  r_q_sum;
    logic [CHIP_W-1:0]            r_chip_bin;

    logic [cwca_pkg::PHASE_W-1:0] n_code_acc;
    logic                         code_carry;
    logic [1:0]                   quad;
    logic signed [SUM_WIDTH-1:0]  i_base;
    logic signed [SUM_WIDTH-1:0]  q_base;
    logic signed [SUM_WIDTH-1:0]  n_i_sum;
    logic signed [SUM_WIDTH-1:0]  n_q_sum;
    logic                         i_neg;
    logic                         q_neg;
    logic [CHIP_W-1:0]            bin_base;
    logic [CHIP_W+cwca_pkg::BIN_W-1:0] bin_ext;

    // Carrier quadrant and wipe-off mismatch flags.
    assign quad  = r_carrier_phase[cwca_pkg::PHASE_W-1 -: 2];
    assign i_neg = i_sample_bit ^ cwca_pkg::SIN_BITS[quad];
    assign q_neg = i_sample_bit ^ cwca_pkg::COS_BITS[quad];

    // Restart clears the sums and the bin before the sample is added.
    assign i_base   = i_restart ? '0 : r_i_sum;
    assign q_base   = i_restart ? '0 : r_q_sum;
    assign bin_base = i_restart ? '0 : r_chip_bin;

    // Saturating add of plus or minus one.
    always_comb begin
        if (i_neg) begin
            n_i_sum = (i_base == SUM_MIN) ? i_base : i_base - SUM_WIDTH'(1);
        end else begin
            n_i_sum = (i_base == SUM_MAX) ? i_base : i_base + SUM_WIDTH'(1);
        end
        if (q_neg) begin
            n_q_sum = (q_base == SUM_MIN) ? q_base : q_base - SUM_WIDTH'(1);
        end else begin
            n_q_sum = (q_base == SUM_MAX) ? q_base : q_base + SUM_WIDTH'(1);
        end
    end

    // Code phase advance; the carry out marks the end of a chip.
    assign {code_carry, n_code_acc} = {1'b0, r_code_acc} + {1'b0, r_code_step};

    // The result word carries the low twelve bits of the chip bin.
    assign bin_ext = {{cwca_pkg::BIN_W{1'b0}}, bin_base};

    always_comb begin
        o_word.valid     = i_accept && code_carry;
        o_word.i_bit     = !n_i_sum[SUM_WIDTH-1] && (n_i_sum != '0);
        o_word.q_bit     = !n_q_sum[SUM_WIDTH-1] && (n_q_sum != '0);
        o_word.bin_index = bin_ext[cwca_pkg::BIN_W-1:0];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_step    <= '0;
            r_carrier_step <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cwca_pkg::CFG_CODE_STEP:    r_code_step    <= i_cfg_data;
                cwca_pkg::CFG_CARRIER_STEP: r_carrier_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accumulator and sum state, advanced once per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_phase <= '0;
            r_code_acc      <= '0;
            r_i_sum         <= '0;
            r_q_sum         <= '0;
            r_chip_bin      <= '0;
        end else if (i_accept) begin
            r_carrier_phase <= r_carrier_phase + r_carrier_step;
            r_code_acc      <= n_code_acc;
            if (code_carry) begin
                r_i_sum    <= '0;
                r_q_sum    <= '0;
                r_chip_bin <= (bin_base == BIN_LAST) ? '0 : bin_base + CHIP_W'(1);
            end else begin
                r_i_sum    <= n_i_sum;
                r_q_sum    <= n_q_sum;
                r_chip_bin <= bin_base;
            end
        end
    end

endmodule

// ----- rtl/core/cwca_out_skid.sv -----
// ----------------------------------------------------------------------------
// cwca_out_skid
// Output register with a skid stage, so samples keep flowing while a word
// waits on the master side.
// ----------------------------------------------------------------------------
module cwca_out_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cwca_pkg::t_chip_word  i_word,
    output logic                  o_in_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cwca_pkg::t_chip_word  o_word
);

    logic                 r_out_valid;
    logic                 r_skid_valid;
    cwca_pkg::t_chip_word r_out;
    cwca_pkg::t_chip_word r_skid;
    logic                 out_free;

    assign out_free   = !r_out_valid || i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_word     = r_out;

    // Valid flags: a new word goes to the output register if it frees up,
    // otherwise it parks in the skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (i_ready) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_word.valid) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (i_word.valid) begin
            if (out_free) begin
                r_out <= i_word;
            end else begin
                r_skid <= i_word;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a word while the output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_word.valid && !r_skid_valid && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("word arriving at a stalled output was not parked");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid
                                       && r_out == $past(r_skid)))
        else $error("skid word did not move to the output register");
`endif

endmodule

// ----- rtl/core/carrier_wipeoff_chip_averager.sv -----
// ----------------------------------------------------------------------------
// carrier_wipeoff_chip_averager
// One-bit IF carrier wipe-off with per-chip integrate and dump of I and Q.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle while o_s_tready is high; the sum and phase update is one pass.
// A chip word is built from the sample that ends the chip and is registered in the output
// register, or parked in the skid stage if the master stalls.
// A two-word output buffer parks one chip word during a master stall; o_s_tready
// is low only while a parked word waits behind the output register.
// Reset (synchronous, active low) clears steps, phases, sums, bin and buffer.
// ----------------------------------------------------------------------------
module carrier_wipeoff_chip_averager #(
    parameter int unsigned BIN_COUNT = 4096,
    parameter int unsigned SUM_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [cwca_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [cwca_pkg::PHASE_W-1:0]      i_cfg_data,
    // Sample words.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // [0] sample_bit, [7:1] zero
    input  logic [0:0]                        i_s_tuser,  // [0] restart
    // Chip words.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [15:0]                       o_m_tdata   // [0] i_bit, [1] q_bit,
                                                          // [13:2] bin_index, [15:14] zero
);

    cwca_pkg::t_chip_word dp_word;
    cwca_pkg::t_chip_word out_word;
    logic                 accept;

    assign accept = i_s_tvalid && o_s_tready;

    cwca_datapath #(
        .BIN_COUNT (BIN_COUNT),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_sample_bit (i_s_tdata[0]),
        .i_restart    (i_s_tuser[0]),
        .o_word       (dp_word)
    );

    cwca_out_skid u_out_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (dp_word),
        .o_in_ready (o_s_tready),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_word     (out_word)
    );

    // Pack the chip word for the master side.
    assign o_m_tdata = {2'b00, out_word.bin_index, out_word.q_bit, out_word.i_bit};

endmodule
